// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/rtp_pkg.sv
package rtp_pkg;

   // Default number of result slots in the output queue.
   localparam int unsigned QueueDepth = 4;

   // Byte positions within the fixed header.
   localparam logic [3:0] SeqStart         = 4'd2;
   localparam logic [3:0] TimeStart        = 4'd4;
   localparam logic [3:0] SsrcStart        = 4'd8;
   localparam logic [3:0] FixedHeaderLast  = 4'd11;
   localparam logic [3:0] WordLast         = 4'd3;
   localparam logic [1:0] RtpVersion       = 2'd2;

   typedef enum logic [2:0] {
      KIND_HEADER   = 3'd0,
      KIND_CSRC     = 3'd1,
      KIND_EXT_HEAD = 3'd2,
      KIND_EXT_BYTE = 3'd3,
      KIND_PAYLOAD  = 3'd4,
      KIND_END      = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_SHORT       = 2'd1,
      STATUS_BAD_VERSION = 2'd2
   } status_type;

   typedef enum logic [5:0] {
      PH_FIXED    = 6'b000001,
      PH_CSRC     = 6'b000010,
      PH_EXT_HEAD = 6'b000100,
      PH_EXT_DATA = 6'b001000,
      PH_PAYLOAD  = 6'b010000,
      PH_ERROR    = 6'b100000
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic       padding_bit;
      logic       extension_bit;
      logic       marker_bit;
      logic [6:0] media_type;
      logic [3:0] contrib_count;
      logic [31:0] time_stamp;
      logic [31:0] source_id;
      logic [31:0] word_value;
      logic [7:0] out_byte;
      status_type status;
      logic       last_of_run;
   } result_type;

endpackage

// File: rtl/core/rtp_req_if.sv
// Byte stream into the parser.
interface rtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/core/rtp_rsp_if.sv
// Parsed results out of the parser.
interface rtp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic        padding_bit;
   logic        extension_bit;
   logic        marker_bit;
   logic [6:0]  media_type;
   logic [3:0]  contrib_count;
   logic [31:0] time_stamp;
   logic [31:0] source_id;
   logic [31:0] word_value;
   logic [7:0]  out_byte;
   logic [1:0]  status;
   logic        last_of_run;

   modport source (
      output valid, output kind, output padding_bit, output extension_bit,
      output marker_bit, output media_type, output contrib_count, output time_stamp,
      output source_id, output word_value, output out_byte, output status,
      output last_of_run, input ready
   );
   modport sink (
      input valid, input kind, input padding_bit, input extension_bit,
      input marker_bit, input media_type, input contrib_count, input time_stamp,
      input source_id, input word_value, input out_byte, input status,
      input last_of_run, output ready
   );
endinterface

// File: rtl/core/rtp_header_parser.sv
// RTP header parser. Packet bytes enter on req_chan one item per clock while
// ready is high, in wire order, with last_byte on the final byte. Each byte is
// parsed in the cycle it is accepted and its results (none, one or two) are
// written to an output queue of QUEUE_DEPTH entries; rsp_chan shows its oldest
// result. The parser sustains one byte per cycle while rsp_chan takes a result
// every cycle; ready falls only when fewer than two queue slots are free, and
// the final byte of a packet that also carries a data result writes two entries,
// which the queue absorbs. Results emitted before an end status of too short or
// bad version belong to a failed packet and must be dropped by the consumer.
// Padding is reported in the header result but not stripped.
`include "assert_macros.svh"

module rtp_header_parser
   import rtp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   rtp_req_if.sink      req_chan,
   rtp_rsp_if.source    rsp_chan
);

   localparam int unsigned PtrWidth   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CountWidth-1:0] ReadyMax  = CountWidth'(QUEUE_DEPTH - 2);

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [3:0]  byte_index_ff, byte_index_in;
   logic [31:0] word_gather_ff, word_gather_in;
   logic [15:0] first_two_ff, first_two_in;
   logic [15:0] seq_hold_ff, seq_hold_in;
   logic [31:0] time_hold_ff, time_hold_in;
   logic [3:0]  csrc_left_ff, csrc_left_in;
   logic [17:0] ext_left_ff, ext_left_in;

   // Output queue.
   result_type              queue_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   logic        req_fire;
   logic        rsp_fire;
   logic [7:0]  in_byte;
   logic        in_last;
   logic [31:0] full_word;
   logic        data_valid;
   logic        end_valid;
   logic        at_header_start;
   result_type  data_res;
   result_type  end_res;
   result_type  head_res;
   phase_type   after_csrc;

   function automatic logic [PtrWidth-1:0] ptr_step(input logic [PtrWidth-1:0] ptr);
      ptr_step = (ptr == PtrLast) ? '0 : ptr + 1'b1;
   endfunction

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rsp_fire  = rsp_chan.valid && rsp_chan.ready;
   assign in_byte   = req_chan.data_byte;
   assign in_last   = req_chan.last_byte;
   assign full_word = {word_gather_ff[23:0], in_byte};
   assign after_csrc = first_two_ff[12] ? PH_EXT_HEAD : PH_PAYLOAD;
   assign at_header_start = (phase_ff == PH_FIXED) && (byte_index_ff == '0);

   // Parse the accepted byte and form up to two results.
   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      word_gather_in = word_gather_ff;
      first_two_in   = first_two_ff;
      seq_hold_in    = seq_hold_ff;
      time_hold_in   = time_hold_ff;
      csrc_left_in   = csrc_left_ff;
      ext_left_in    = ext_left_ff;
      data_valid     = 1'b0;
      end_valid      = 1'b0;
      data_res       = '0;
      end_res        = '0;

      if (req_fire) begin
         case (phase_ff)
            PH_FIXED: begin
               if (byte_index_ff < SeqStart) begin
                  first_two_in = {first_two_ff[7:0], in_byte};
               end else if (byte_index_ff < TimeStart) begin
                  seq_hold_in = {seq_hold_ff[7:0], in_byte};
               end else if (byte_index_ff < SsrcStart) begin
                  time_hold_in = {time_hold_ff[23:0], in_byte};
               end else begin
                  word_gather_in = full_word;
               end
               if (byte_index_ff == FixedHeaderLast) begin
                  byte_index_in = '0;
                  if (first_two_ff[15:14] != RtpVersion) begin
                     phase_in = PH_ERROR;
                  end else begin
                     data_valid             = 1'b1;
                     data_res.kind          = KIND_HEADER;
                     data_res.padding_bit   = first_two_ff[13];
                     data_res.extension_bit = first_two_ff[12];
                     data_res.marker_bit    = first_two_ff[7];
                     data_res.media_type    = first_two_ff[6:0];
                     data_res.contrib_count = first_two_ff[11:8];
                     data_res.time_stamp    = time_hold_ff;
                     data_res.source_id     = full_word;
                     data_res.word_value    = {16'd0, seq_hold_ff};
                     csrc_left_in           = first_two_ff[11:8];
                     word_gather_in         = '0;
                     phase_in = (first_two_ff[11:8] != 4'd0) ? PH_CSRC : after_csrc;
                  end
               end else begin
                  byte_index_in = byte_index_ff + 4'd1;
               end
            end
            PH_CSRC: begin
               word_gather_in = full_word;
               if (byte_index_ff == WordLast) begin
                  byte_index_in       = '0;
                  data_valid          = 1'b1;
                  data_res.kind       = KIND_CSRC;
                  data_res.word_value = full_word;
                  word_gather_in      = '0;
                  csrc_left_in        = csrc_left_ff - 4'd1;
                  if (csrc_left_ff == 4'd1) begin
                     phase_in = after_csrc;
                  end
               end else begin
                  byte_index_in = byte_index_ff + 4'd1;
               end
            end
            PH_EXT_HEAD: begin
               word_gather_in = full_word;
               if (byte_index_ff == WordLast) begin
                  byte_index_in       = '0;
                  data_valid          = 1'b1;
                  data_res.kind       = KIND_EXT_HEAD;
                  data_res.word_value = full_word;
                  word_gather_in      = '0;
                  ext_left_in         = {full_word[15:0], 2'b00};
                  phase_in = (full_word[15:0] != 16'd0) ? PH_EXT_DATA : PH_PAYLOAD;
               end else begin
                  byte_index_in = byte_index_ff + 4'd1;
               end
            end
            PH_EXT_DATA: begin
               data_valid        = 1'b1;
               data_res.kind     = KIND_EXT_BYTE;
               data_res.out_byte = in_byte;
               ext_left_in       = ext_left_ff - 18'd1;
               if (ext_left_ff == 18'd1) begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               data_valid        = 1'b1;
               data_res.kind     = KIND_PAYLOAD;
               data_res.out_byte = in_byte;
            end
            default: begin
               // Error drain: bytes are swallowed until the end of the packet.
            end
         endcase

         // End of packet: report status and return to the start of a header.
         if (in_last) begin
            end_valid           = 1'b1;
            end_res.kind        = KIND_END;
            end_res.last_of_run = 1'b1;
            if (phase_in == PH_ERROR) begin
               end_res.status = STATUS_BAD_VERSION;
            end else if (phase_in == PH_PAYLOAD) begin
               end_res.status = STATUS_OK;
            end else begin
               end_res.status = STATUS_SHORT;
            end
            phase_in      = PH_FIXED;
            byte_index_in = '0;
            csrc_left_in  = '0;
            ext_left_in   = '0;
         end
         data_res.last_of_run = !in_last;
      end
   end

   // Queue pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (data_valid && end_valid) begin
         wr_ptr_in = ptr_step(ptr_step(wr_ptr_ff));
      end else if (data_valid || end_valid) begin
         wr_ptr_in = ptr_step(wr_ptr_ff);
      end
      rd_ptr_in = rsp_fire ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CountWidth'(data_valid) + CountWidth'(end_valid)
                  - CountWidth'(rsp_fire);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIXED;
         byte_index_ff <= '0;
         csrc_left_ff  <= '0;
         ext_left_ff   <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         csrc_left_ff  <= csrc_left_in;
         ext_left_ff   <= ext_left_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   // Header gather registers.
   always_ff @(posedge clock) begin
      word_gather_ff <= word_gather_in;
      first_two_ff   <= first_two_in;
      seq_hold_ff    <= seq_hold_in;
      time_hold_ff   <= time_hold_in;
   end

   // Queue storage: the data result goes first, the end status after it.
   always_ff @(posedge clock) begin
      if (data_valid) begin
         queue_ff[wr_ptr_ff] <= data_res;
      end else if (end_valid) begin
         queue_ff[wr_ptr_ff] <= end_res;
      end
      if (data_valid && end_valid) begin
         queue_ff[ptr_step(wr_ptr_ff)] <= end_res;
      end
   end

   // Result channel.
   assign head_res               = queue_ff[rd_ptr_ff];
   assign req_chan.ready         = (count_ff <= ReadyMax);
   assign rsp_chan.valid         = (count_ff != '0);
   assign rsp_chan.kind          = head_res.kind;
   assign rsp_chan.padding_bit   = head_res.padding_bit;
   assign rsp_chan.extension_bit = head_res.extension_bit;
   assign rsp_chan.marker_bit    = head_res.marker_bit;
   assign rsp_chan.media_type    = head_res.media_type;
   assign rsp_chan.contrib_count = head_res.contrib_count;
   assign rsp_chan.time_stamp    = head_res.time_stamp;
   assign rsp_chan.source_id     = head_res.source_id;
   assign rsp_chan.word_value    = head_res.word_value;
   assign rsp_chan.out_byte      = head_res.out_byte;
   assign rsp_chan.status        = head_res.status;
   assign rsp_chan.last_of_run   = head_res.last_of_run;

   // Checks on the parser and queue.
   `ASSERT_SAME_CYCLE(a_queue_bound, clock, reset, 1'b1, count_ff <= CountWidth'(QUEUE_DEPTH))
   `ASSERT_NEXT_CYCLE(a_packet_restart, clock, reset, req_fire && in_last, at_header_start)
   `ASSERT_SAME_CYCLE(a_header_index, clock, reset, phase_ff == PH_FIXED, byte_index_ff <= FixedHeaderLast)
   `ASSERT_SAME_CYCLE(a_csrc_pending, clock, reset, phase_ff == PH_CSRC, csrc_left_ff != 4'd0)

endmodule

// File: dv/rtp_header_parser_test.sv
module rtp_header_parser_test;
   import rtp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0] byte_queue_type[$];

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_BYTES = 420;
   localparam int REPORT_LIMIT = 100;

   logic clock;
   logic reset;

   rtp_req_if req_chan ();
   rtp_rsp_if rsp_chan ();

   rtp_header_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Parser state as the packet is expected to leave it.
   phase_type   pred_phase;
   logic [17:0] pred_index;
   logic [31:0] pred_word;
   logic [15:0] pred_first;
   logic [15:0] pred_seq;
   logic [31:0] pred_time;
   logic [3:0]  pred_csrc_left;
   logic [17:0] pred_ext_left;
   status_type  pred_error;

   result_type expected_results[$];
   int failures = 0;
   int cycle_count = 0;
   int send_calm = 0;
   int stall_calm = 0;
   int stall_left = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("rtp_header_parser_test NOT OK");
         $finish;
      end
   end

   // Length of an idle stretch: mostly none or short, a few long, and now and then a
   // calm run with no idling at all.
   function automatic int idle_cycles(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic void clear_parser_state();
      pred_phase     = PH_FIXED;
      pred_index     = '0;
      pred_word      = '0;
      pred_first     = '0;
      pred_seq       = '0;
      pred_time      = '0;
      pred_csrc_left = '0;
      pred_ext_left  = '0;
      pred_error     = STATUS_OK;
   endfunction

   function automatic phase_type phase_after_csrc();
      return pred_first[12] ? PH_EXT_HEAD : PH_PAYLOAD;
   endfunction

   // Advances the parser state by one packet byte and queues the results it causes.
   function automatic void parse_byte(input logic [7:0] b, input logic last);
      result_type produced[2];
      result_type r;
      int n;
      n = 0;
      r = '0;
      case (pred_phase)
         PH_FIXED: begin
            if (pred_index < 2) pred_first = {pred_first[7:0], b};
            else if (pred_index < 4) pred_seq = {pred_seq[7:0], b};
            else if (pred_index < 8) pred_time = {pred_time[23:0], b};
            else pred_word = {pred_word[23:0], b};
            pred_index = pred_index + 18'd1;
            if (pred_index == 18'd12) begin
               pred_index = '0;
               if (pred_first[15:14] != RtpVersion) begin
                  pred_error = STATUS_BAD_VERSION;
                  pred_phase = PH_ERROR;
               end else begin
                  r.kind          = KIND_HEADER;
                  r.padding_bit   = pred_first[13];
                  r.extension_bit = pred_first[12];
                  r.marker_bit    = pred_first[7];
                  r.media_type    = pred_first[6:0];
                  r.contrib_count = pred_first[11:8];
                  r.time_stamp    = pred_time;
                  r.source_id     = pred_word;
                  r.word_value    = {16'h0000, pred_seq};
                  produced[n] = r;
                  n++;
                  pred_csrc_left = pred_first[11:8];
                  pred_word = '0;
                  pred_phase = (pred_csrc_left != 0) ? PH_CSRC : phase_after_csrc();
               end
            end
         end
         PH_CSRC: begin
            pred_word = {pred_word[23:0], b};
            pred_index = pred_index + 18'd1;
            if (pred_index >= 18'd4) begin
               pred_index = '0;
               r.kind = KIND_CSRC;
               r.word_value = pred_word;
               produced[n] = r;
               n++;
               pred_word = '0;
               pred_csrc_left = pred_csrc_left - 4'd1;
               if (pred_csrc_left == 0) pred_phase = phase_after_csrc();
            end
         end
         PH_EXT_HEAD: begin
            pred_word = {pred_word[23:0], b};
            pred_index = pred_index + 18'd1;
            if (pred_index >= 18'd4) begin
               pred_index = '0;
               r.kind = KIND_EXT_HEAD;
               r.word_value = pred_word;
               produced[n] = r;
               n++;
               pred_ext_left = {pred_word[15:0], 2'b00};
               pred_word = '0;
               pred_phase = (pred_ext_left != 0) ? PH_EXT_DATA : PH_PAYLOAD;
            end
         end
         PH_EXT_DATA: begin
            r.kind = KIND_EXT_BYTE;
            r.out_byte = b;
            produced[n] = r;
            n++;
            pred_ext_left = pred_ext_left - 18'd1;
            if (pred_ext_left == 0) pred_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            r.kind = KIND_PAYLOAD;
            r.out_byte = b;
            produced[n] = r;
            n++;
         end
         default: begin
         end
      endcase

      // The final byte closes the packet with a status and starts afresh.
      if (last) begin
         r = '0;
         r.kind = KIND_END;
         if (pred_error != STATUS_OK) r.status = pred_error;
         else if (pred_phase == PH_PAYLOAD) r.status = STATUS_OK;
         else r.status = STATUS_SHORT;
         produced[n] = r;
         n++;
         clear_parser_state();
      end

      if (n > 0) produced[n - 1].last_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_results.insert(expected_results.size(), produced[i]);
   endfunction

   // Offers one item, after a random idle stretch, and predicts its results once taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = idle_cycles(send_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.last_byte <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      parse_byte(b, last);
   endtask

   task automatic send_packet(input byte_queue_type pkt);
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
   endtask

   function automatic logic [7:0] fill_byte(input int fill);
      return (fill < 0) ? 8'($urandom) : 8'(fill);
   endfunction

   // Lays out a packet in wire order. A negative fill gives random content bytes.
   function automatic byte_queue_type build_packet(input logic [1:0] version, input logic pad,
                                                   input logic ext, input logic mark,
                                                   input logic [6:0] ptype,
                                                   input logic [3:0] count,
                                                   input logic [15:0] ext_words,
                                                   input int ext_bytes, input int body_len,
                                                   input int fill);
      byte_queue_type pkt;
      pkt.insert(pkt.size(), {version, pad, ext, count});
      pkt.insert(pkt.size(), {mark, ptype});
      repeat (10 + 4 * count) pkt.insert(pkt.size(), fill_byte(fill));
      if (ext) begin
         repeat (2) pkt.insert(pkt.size(), fill_byte(fill));
         pkt.insert(pkt.size(), ext_words[15:8]);
         pkt.insert(pkt.size(), ext_words[7:0]);
         repeat (ext_bytes) pkt.insert(pkt.size(), fill_byte(fill));
      end
      repeat (body_len) pkt.insert(pkt.size(), fill_byte(fill));
      return pkt;
   endfunction

   function automatic byte_queue_type random_packet();
      logic [3:0]  count;
      logic [15:0] words;
      int          plen;
      count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, 2));
      words = 16'($urandom_range(0, 3));
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16);
      return build_packet(RtpVersion, 1'($urandom), 1'($urandom), 1'($urandom),
                          7'($urandom), count, words, 4 * words, plen, -1);
   endfunction

   function automatic logic [1:0] wrong_version();
      logic [1:0] v;
      v = 2'($urandom_range(0, 2));
      return (v == RtpVersion) ? 2'd3 : v;
   endfunction

   // Header fields at both extremes, and a packet that ends right after its header.
   task automatic test_header_extremes();
      send_packet(build_packet(RtpVersion, 1'b0, 1'b0, 1'b0, 7'h00, 4'h0, 16'h0000,
                               0, 0, 8'h00));
      send_packet(build_packet(RtpVersion, 1'b1, 1'b0, 1'b1, 7'h7F, 4'hF, 16'h0000,
                               0, 2, 8'hFF));
   endtask

   // Every wrong version is caught at the end of the fixed header.
   task automatic test_bad_version();
      send_packet(build_packet(2'd0, 1'b0, 1'b0, 1'b0, 7'h00, 4'h0, 16'h0000, 0, 2, -1));
      send_packet(build_packet(2'd1, 1'b1, 1'b1, 1'b1, 7'h7F, 4'hF, 16'h0000, 0, 0, -1));
      send_packet(build_packet(2'd3, 1'b0, 1'b0, 1'b1, 7'h35, 4'h0, 16'h0000, 0, 3, -1));
   endtask

   // Packets that end in each part of the header.
   task automatic test_short_packets();
      byte_queue_type pkt;
      // A single byte, and a short packet whose version is also wrong.
      pkt = build_packet(RtpVersion, 1'b0, 1'b0, 1'b0, 7'h60, 4'h0, 16'h0000, 0, 0, -1);
      send_packet(pkt[0:0]);
      pkt = build_packet(2'd1, 1'b0, 1'b0, 1'b0, 7'h11, 4'h0, 16'h0000, 0, 0, -1);
      send_packet(pkt[0:10]);
      // Cut inside the CSRC list.
      pkt = build_packet(RtpVersion, 1'b0, 1'b0, 1'b0, 7'h08, 4'h2, 16'h0000, 0, 4, -1);
      send_packet(pkt[0:13]);
      // Cut inside the extension head.
      pkt = build_packet(RtpVersion, 1'b0, 1'b1, 1'b0, 7'h08, 4'h0, 16'h0001, 4, 0, -1);
      send_packet(pkt[0:13]);
      // Cut inside the longest possible extension.
      send_packet(build_packet(RtpVersion, 1'b1, 1'b1, 1'b0, 7'h21, 4'h0, 16'hFFFF, 3, 0,
                               -1));
   endtask

   // An empty extension, and an extension followed by payload.
   task automatic test_extension_cases();
      send_packet(build_packet(RtpVersion, 1'b0, 1'b1, 1'b1, 7'h00, 4'h0, 16'h0000, 0, 0,
                               -1));
      send_packet(build_packet(RtpVersion, 1'b1, 1'b1, 1'b0, 7'h60, 4'h1, 16'h0001, 4, 3,
                               -1));
   endtask

   // Mostly well-formed packets with random content; the rest cut short, with a wrong
   // version, with a huge extension cut off, or plain noise.
   task automatic test_random_packets();
      byte_queue_type pkt;
      int counted;
      int pick;
      int cut;
      counted = 0;
      while (counted < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         pkt = random_packet();
         if (pick < 72) begin
         end else if (pick < 84) begin
            cut = $urandom_range(1, pkt.size() - 1);
            pkt = pkt[0:cut - 1];
         end else if (pick < 89) begin
            pkt = build_packet(RtpVersion, 1'($urandom), 1'b1, 1'($urandom), 7'($urandom),
                               4'($urandom_range(0, 1)), 16'($urandom),
                               $urandom_range(0, 8), 0, -1);
         end else if (pick < 96) begin
            pkt[0] = {wrong_version(), pkt[0][5:0]};
         end else begin
            pkt = {};
            repeat ($urandom_range(1, 30)) pkt.insert(pkt.size(), 8'($urandom));
         end
         send_packet(pkt);
         counted += pkt.size();
      end
   endtask

   // Result side: ready drops for random stretches.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = idle_cycles(stall_calm);
         end
      end
   end

   function automatic void compare_field(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
      end
   endfunction

   // Each result taken is matched against the oldest one still expected.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: result expected none actual kind %0d", $time, rsp_chan.kind);
         end else begin
            want = expected_results.pop_front();
            compare_field("kind", 32'(want.kind), 32'(rsp_chan.kind));
            compare_field("padding_bit", 32'(want.padding_bit), 32'(rsp_chan.padding_bit));
            compare_field("extension_bit", 32'(want.extension_bit),
                          32'(rsp_chan.extension_bit));
            compare_field("marker_bit", 32'(want.marker_bit), 32'(rsp_chan.marker_bit));
            compare_field("media_type", 32'(want.media_type),
                          32'(rsp_chan.media_type));
            compare_field("contrib_count", 32'(want.contrib_count),
                          32'(rsp_chan.contrib_count));
            compare_field("time_stamp", want.time_stamp, rsp_chan.time_stamp);
            compare_field("source_id", want.source_id, rsp_chan.source_id);
            compare_field("word_value", want.word_value, rsp_chan.word_value);
            compare_field("out_byte", 32'(want.out_byte), 32'(rsp_chan.out_byte));
            compare_field("status", 32'(want.status), 32'(rsp_chan.status));
            compare_field("last_of_run", 32'(want.last_of_run), 32'(rsp_chan.last_of_run));
         end
      end
   end

   // Reset, the tests in turn, then drain and report.
   initial begin
      req_chan.valid <= 1'b0;
      req_chan.data_byte <= 8'h00;
      req_chan.last_byte <= 1'b0;
      reset <= 1'b1;
      clear_parser_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_header_extremes();
      test_bad_version();
      test_short_packets();
      test_extension_cases();
      test_random_packets();

      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("rtp_header_parser_test OK");
      end else begin
         $display("rtp_header_parser_test NOT OK");
      end
      $finish;
   end

endmodule
